### design/gitc_pkg.sv
package gitc_pkg;

   localparam int unsigned AddrWidth = 5;
   localparam int unsigned DataWidth = 32;

   typedef enum logic [2:0] {
      ST_OFF       = 3'd0,
      ST_TO_GRID   = 3'd1,
      ST_TO_ISLAND = 3'd2,
      ST_GRID      = 3'd3,
      ST_ISLAND    = 3'd4,
      ST_ERROR     = 3'd5
   } state_type;

   typedef enum logic [1:0] {
      MODE_OFF       = 2'd0,
      MODE_AUTOMATIC = 2'd1,
      MODE_ISLAND    = 2'd2,
      MODE_GRID      = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_TEMP         = 3'd1,
      ERR_OV           = 3'd2,
      ERR_STUCK_GRID   = 3'd3,
      ERR_STUCK_ISLAND = 3'd4
   } error_type;

   localparam logic [2:0] REG_SOC_MIN       = 3'd0;
   localparam logic [2:0] REG_SOC_MAX       = 3'd1;
   localparam logic [2:0] REG_SOC_EMERGENCY = 3'd2;
   localparam logic [2:0] REG_SWITCH_VOLT   = 3'd3;
   localparam logic [2:0] REG_RELAY_TIMEOUT = 3'd4;

   localparam logic [9:0]  SOC_MIN_RESET       = 10'd300;
   localparam logic [9:0]  SOC_MAX_RESET       = 10'd900;
   localparam logic [9:0]  SOC_EMERGENCY_RESET = 10'd100;
   localparam logic [11:0] SWITCH_VOLT_RESET   = 12'd200;
   localparam logic [15:0] RELAY_TIMEOUT_RESET = 16'd2000;

   typedef struct packed {
      logic [9:0]  soc_min;
      logic [9:0]  soc_max;
      logic [9:0]  soc_emergency;
      logic [11:0] switch_voltage;
      logic [15:0] relay_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic        cmd;
      mode_type    mode;
      logic        over_temperature;
      logic        grid_overvoltage;
      logic        grid_present;
      logic        load_live;
      logic [9:0]  charge_level;
      logic [11:0] load_voltage;
      logic [31:0] now_ms;
   } item_type;

   typedef struct packed {
      state_type supply_state;
      logic      grid_relay_on;
      logic      island_relay_on;
      logic      path_select;
      error_type error_code;
   } result_type;

endpackage

### design/gitc_csr.sv
module gitc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [gitc_pkg::AddrWidth-1:0]      csr_paddr,
   input  logic [gitc_pkg::DataWidth-1:0]      csr_pwdata,
   output logic [gitc_pkg::DataWidth-1:0]      csr_prdata,
   output gitc_pkg::cfg_type                   cfg
);

   gitc_pkg::cfg_type cfg_ff;
   gitc_pkg::cfg_type cfg_in;
   logic [2:0]        index;
   logic              write_en;

   assign index    = csr_paddr[4:2];
   assign write_en = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         unique case (index)
            gitc_pkg::REG_SOC_MIN:       cfg_in.soc_min          = csr_pwdata[9:0];
            gitc_pkg::REG_SOC_MAX:       cfg_in.soc_max          = csr_pwdata[9:0];
            gitc_pkg::REG_SOC_EMERGENCY: cfg_in.soc_emergency    = csr_pwdata[9:0];
            gitc_pkg::REG_SWITCH_VOLT:   cfg_in.switch_voltage   = csr_pwdata[11:0];
            gitc_pkg::REG_RELAY_TIMEOUT: cfg_in.relay_timeout_ms = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         gitc_pkg::REG_SOC_MIN:       csr_prdata = {22'd0, cfg_ff.soc_min};
         gitc_pkg::REG_SOC_MAX:       csr_prdata = {22'd0, cfg_ff.soc_max};
         gitc_pkg::REG_SOC_EMERGENCY: csr_prdata = {22'd0, cfg_ff.soc_emergency};
         gitc_pkg::REG_SWITCH_VOLT:   csr_prdata = {20'd0, cfg_ff.switch_voltage};
         gitc_pkg::REG_RELAY_TIMEOUT: csr_prdata = {16'd0, cfg_ff.relay_timeout_ms};
         default:                     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soc_min          <= gitc_pkg::SOC_MIN_RESET;
         cfg_ff.soc_max          <= gitc_pkg::SOC_MAX_RESET;
         cfg_ff.soc_emergency    <= gitc_pkg::SOC_EMERGENCY_RESET;
         cfg_ff.switch_voltage   <= gitc_pkg::SWITCH_VOLT_RESET;
         cfg_ff.relay_timeout_ms <= gitc_pkg::RELAY_TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/gitc_core.sv
module gitc_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  gitc_pkg::item_type     item,
   input  gitc_pkg::cfg_type      cfg,
   output gitc_pkg::result_type   result
);

   gitc_pkg::state_type state_ff, state_in;
   gitc_pkg::error_type error_ff, error_in;
   logic [31:0]         start_ff, start_in;
   logic                path_ff, path_in;
   logic                dead;
   logic                grid;
   logic [31:0]         elapsed;
   logic                timed_out;

   assign dead      = item.load_voltage < cfg.switch_voltage;
   assign grid      = item.grid_present;
   assign elapsed   = item.now_ms - start_ff;
   assign timed_out = elapsed >= {16'd0, cfg.relay_timeout_ms};

   always_comb begin
      state_in = state_ff;
      error_in = error_ff;
      start_in = start_ff;
      path_in  = path_ff;
      if (item.cmd) begin
         if (state_ff == gitc_pkg::ST_ERROR) begin
            error_in = gitc_pkg::ERR_NONE;
            state_in = gitc_pkg::ST_OFF;
         end
      end else if (state_ff != gitc_pkg::ST_ERROR && item.over_temperature) begin
         state_in = gitc_pkg::ST_ERROR;
         error_in = gitc_pkg::ERR_TEMP;
      end else if (state_ff != gitc_pkg::ST_ERROR && item.grid_overvoltage) begin
         state_in = gitc_pkg::ST_ERROR;
         error_in = gitc_pkg::ERR_OV;
      end else begin
         unique case (state_ff)
            gitc_pkg::ST_OFF: begin
               if (item.mode == gitc_pkg::MODE_AUTOMATIC) begin
                  if (item.charge_level >= cfg.soc_min && !grid && dead) begin
                     state_in = gitc_pkg::ST_TO_ISLAND;
                     start_in = item.now_ms;
                  end else if (item.charge_level < cfg.soc_max && grid && dead) begin
                     state_in = gitc_pkg::ST_TO_GRID;
                     start_in = item.now_ms;
                  end
               end else if (item.mode == gitc_pkg::MODE_ISLAND) begin
                  if (item.charge_level > cfg.soc_emergency && dead) begin
                     state_in = gitc_pkg::ST_TO_ISLAND;
                     start_in = item.now_ms;
                  end
               end else if (item.mode == gitc_pkg::MODE_GRID) begin
                  if (grid && dead) begin
                     state_in = gitc_pkg::ST_TO_GRID;
                     start_in = item.now_ms;
                  end
               end
            end
            gitc_pkg::ST_ISLAND: begin
               if (item.charge_level < cfg.soc_emergency) begin
                  state_in = gitc_pkg::ST_OFF;
               end else if (item.mode == gitc_pkg::MODE_AUTOMATIC) begin
                  if (item.charge_level < cfg.soc_min && grid) begin
                     state_in = gitc_pkg::ST_TO_GRID;
                     start_in = item.now_ms;
                  end
               end else if (item.mode == gitc_pkg::MODE_OFF) begin
                  state_in = gitc_pkg::ST_OFF;
               end else if (item.mode == gitc_pkg::MODE_GRID && grid) begin
                  state_in = gitc_pkg::ST_TO_GRID;
                  start_in = item.now_ms;
               end
            end
            gitc_pkg::ST_GRID: begin
               if (item.mode == gitc_pkg::MODE_AUTOMATIC) begin
                  if (!grid && item.charge_level >= cfg.soc_min) begin
                     state_in = gitc_pkg::ST_TO_ISLAND;
                     start_in = item.now_ms;
                  end else if (!grid) begin
                     state_in = gitc_pkg::ST_OFF;
                  end else if (item.charge_level > cfg.soc_max) begin
                     state_in = gitc_pkg::ST_TO_ISLAND;
                     start_in = item.now_ms;
                  end
               end else if (item.mode == gitc_pkg::MODE_OFF) begin
                  state_in = gitc_pkg::ST_OFF;
               end else if (item.mode == gitc_pkg::MODE_ISLAND
                            && item.charge_level > cfg.soc_emergency) begin
                  state_in = gitc_pkg::ST_TO_ISLAND;
                  start_in = item.now_ms;
               end
            end
            gitc_pkg::ST_TO_GRID: begin
               if (!item.load_live) begin
                  state_in = gitc_pkg::ST_GRID;
                  path_in  = 1'b0;
               end else if (timed_out) begin
                  state_in = gitc_pkg::ST_ERROR;
                  error_in = gitc_pkg::ERR_STUCK_GRID;
               end
            end
            gitc_pkg::ST_TO_ISLAND: begin
               if (!item.load_live) begin
                  state_in = gitc_pkg::ST_ISLAND;
                  path_in  = 1'b1;
               end else if (timed_out) begin
                  state_in = gitc_pkg::ST_ERROR;
                  error_in = gitc_pkg::ERR_STUCK_ISLAND;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gitc_pkg::ST_OFF;
         error_ff <= gitc_pkg::ERR_NONE;
         start_ff <= '0;
         path_ff  <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
         error_ff <= error_in;
         start_ff <= start_in;
         path_ff  <= path_in;
      end
   end

   assign result.supply_state    = state_in;
   assign result.grid_relay_on   = state_in == gitc_pkg::ST_GRID;
   assign result.island_relay_on = state_in == gitc_pkg::ST_ISLAND;
   assign result.path_select     = path_in;
   assign result.error_code      = error_in;

endmodule

### design/grid_island_transfer_controller.sv
// Grid / island supply transfer controller. Each transaction on req_ is either a
// tick of sensor readings or a clear-error command and yields exactly one
// transaction on rsp_ with the supply state, relay drives, path select and error
// code after the update. A transaction is registered on entry and the state update
// is combinational logic from that register into the result register, so one
// transaction is taken every cycle while rsp_ready is high; the result register lets
// a new transaction enter while the previous result waits. Thresholds and the relay
// timeout are written through the psel/paddr port; the user must write them only
// while no transaction is in flight, which the block itself does not enforce.
module grid_island_transfer_controller (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_cmd,
   input  logic [1:0]                       req_mode,
   input  logic                             req_over_temperature,
   input  logic                             req_grid_overvoltage,
   input  logic                             req_grid_present,
   input  logic                             req_load_live,
   input  logic [9:0]                       req_charge_level,
   input  logic [11:0]                      req_load_voltage,
   input  logic [31:0]                      req_now_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_supply_state,
   output logic                             rsp_grid_relay_on,
   output logic                             rsp_island_relay_on,
   output logic                             rsp_path_select,
   output logic [2:0]                       rsp_error_code,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gitc_pkg::AddrWidth-1:0]   paddr,
   input  logic [gitc_pkg::DataWidth-1:0]   pwdata,
   output logic [gitc_pkg::DataWidth-1:0]   prdata,
   output logic                             pready
);

   gitc_pkg::cfg_type    cfg;
   gitc_pkg::item_type   item_ff, item_in;
   gitc_pkg::result_type result_ff, result_in;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 req_take;

   assign pready = 1'b1;

   gitc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (psel),
      .csr_penable (penable),
      .csr_pwrite  (pwrite),
      .csr_paddr   (paddr),
      .csr_pwdata  (pwdata),
      .csr_prdata  (prdata),
      .cfg         (cfg)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign req_take  = req_valid & req_ready;

   assign in_valid_in  = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   always_comb begin
      item_in.cmd              = req_cmd;
      item_in.mode             = gitc_pkg::mode_type'(req_mode);
      item_in.over_temperature = req_over_temperature;
      item_in.grid_overvoltage = req_grid_overvoltage;
      item_in.grid_present     = req_grid_present;
      item_in.load_live        = req_load_live;
      item_in.charge_level     = req_charge_level;
      item_in.load_voltage     = req_load_voltage;
      item_in.now_ms           = req_now_ms;
   end

   gitc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_supply_state    = result_ff.supply_state;
   assign rsp_grid_relay_on   = result_ff.grid_relay_on;
   assign rsp_island_relay_on = result_ff.island_relay_on;
   assign rsp_path_select     = result_ff.path_select;
   assign rsp_error_code      = result_ff.error_code;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != gitc_pkg::ERR_NONE
         |-> rsp_supply_state == gitc_pkg::ST_ERROR)
      else $error("error code reported outside the error state");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_grid_relay_on && rsp_island_relay_on))
      else $error("both relays driven");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |-> !req_ready)
      else $error("input register overwritten while held");

   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("processed transaction lost");

endmodule
